FILE: rtl/prh_pkg.sv
// shared types and constants of the probe rtt hop statistics block
package prh_pkg;

    // field widths
    localparam int HOP_W     = 5;
    localparam int SEQ_W     = 16;
    localparam int DATA_W    = 32;
    localparam int TOTAL_W   = 48;
    localparam int SEQ_OUT_W = 8;
    localparam int ALU_W     = 48;
    localparam int S_PAD_W   = 3;
    localparam int M_PAD_W   = 3;

    // result status codes
    localparam logic [1:0] STATUS_ISSUED   = 2'd0;
    localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
    localparam logic [1:0] STATUS_IGNORED  = 2'd2;

    // item kind carried on the input tuser
    typedef enum logic {
        OP_SEND  = 1'b0,
        OP_REPLY = 1'b1
    } op_t;

    // sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PROBE,
        ST_LOOKUP,
        ST_MATCH,
        ST_HOP_RD,
        ST_LOAD,
        ST_ADDR,
        ST_BEST,
        ST_WORST,
        ST_TOTAL,
        ST_RETURN,
        ST_SENT,
        ST_WRITE
    } state_t;

    // shared adder operation
    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic               carry;
        logic [ALU_W-1:0]   sum;
    } alu_res_t;

    // one entry of the sequence table
    typedef struct packed {
        logic               in_flight;
        logic [HOP_W-1:0]   hop;
        logic [DATA_W-1:0]  send_time;
    } slot_entry_t;

    // per-hop statistics record
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [DATA_W-1:0]  addr;
        logic [DATA_W-1:0]  inconsist;
        logic [DATA_W-1:0]  sent;
        logic [DATA_W-1:0]  returned;
        logic [DATA_W-1:0]  best;
        logic [DATA_W-1:0]  worst;
    } hop_stats_t;

    // input tdata layout, last field in the lowest bits
    typedef struct packed {
        logic [S_PAD_W-1:0] pad;
        logic [DATA_W-1:0]  timestamp_us;
        logic [DATA_W-1:0]  reply_addr;
        logic [SEQ_W-1:0]   seq_number;
        logic [HOP_W-1:0]   hop_index;
    } in_item_t;

    // output tdata layout, last field in the lowest bits
    typedef struct packed {
        logic [M_PAD_W-1:0]   pad;
        logic [DATA_W-1:0]    hop_address;
        logic [DATA_W-1:0]    inconsist_count;
        logic [DATA_W-1:0]    sent_count;
        logic [DATA_W-1:0]    returned_count;
        logic [TOTAL_W-1:0]   total_us;
        logic [DATA_W-1:0]    worst_us;
        logic [DATA_W-1:0]    best_us;
        logic [DATA_W-1:0]    rtt_us;
        logic [SEQ_OUT_W-1:0] seq_out;
        logic [HOP_W-1:0]     hop_out;
    } result_t;

    localparam int S_TDATA_W = $bits(in_item_t);
    localparam int M_TDATA_W = $bits(result_t);

endpackage

FILE: rtl/prh_ram.sv
// generic simple dual-port ram with registered read
module prh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: rtl/prh_alu.sv
// shared 48-bit add and subtract unit with carry out
module prh_alu (
    input  prh_pkg::alu_req_t req,
    output prh_pkg::alu_res_t res
);

    localparam int ALU_W = prh_pkg::ALU_W;

    logic [ALU_W-1:0] b_eff;
    logic             is_sub;

    // subtract as a plus inverted b plus one; carry set means no borrow
    assign is_sub = (req.op == prh_pkg::ALU_SUB);
    assign b_eff  = is_sub ? ~req.b : req.b;
    assign {res.carry, res.sum} = {1'b0, req.a} + {1'b0, b_eff} + (ALU_W + 1)'(is_sub);

endmodule

FILE: rtl/probe_rtt_hop_statistics.sv
// probe slot tracking and per-hop rtt statistics, top level
// sequencing: a probe steps through PROBE, LOAD, SENT and WRITE, a matched reply through
//   LOOKUP, MATCH, HOP_RD, LOAD, ADDR, BEST, WORST, TOTAL, RETURN and WRITE, an ignored
//   reply through LOOKUP and MATCH; a new item is taken only in IDLE, once the result is
//   loaded into a free output register, as the sequencer steps all statistics through one shared adder
// reset: rst_n clears control at once, then a clearing pass over the larger table depth
//   zeroes the sequence and hop tables before the first item is taken
module probe_rtt_hop_statistics #(
    parameter int SEQ_ENTRIES = 256,
    parameter int HOP_COUNT   = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // hop_index, seq_number, reply_addr, timestamp_us
    input  logic [prh_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [0:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // hop_out, seq_out, rtt_us, best_us, worst_us, total_us, returned_count,
    // sent_count, inconsist_count, hop_address
    output logic [prh_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [1:0]                     m_tuser
);

    localparam int HOP_W     = prh_pkg::HOP_W;
    localparam int SEQ_W     = prh_pkg::SEQ_W;
    localparam int DATA_W    = prh_pkg::DATA_W;
    localparam int ALU_W     = prh_pkg::ALU_W;
    localparam int SEQ_OUT_W = prh_pkg::SEQ_OUT_W;
    localparam int SEQ_AW    = $clog2(SEQ_ENTRIES);
    localparam int HOP_AW    = $clog2(HOP_COUNT);
    localparam int CLR_DEPTH = (SEQ_ENTRIES > HOP_COUNT) ? SEQ_ENTRIES : HOP_COUNT;
    localparam int CLR_AW    = $clog2(CLR_DEPTH);
    localparam int SLOT_W    = $bits(prh_pkg::slot_entry_t);
    localparam int STATS_W   = $bits(prh_pkg::hop_stats_t);

    prh_pkg::state_t      state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [SEQ_AW-1:0]    next_slot_reg, next_slot_next;
    logic [CLR_AW-1:0]    clr_cnt_reg, clr_cnt_next;

    prh_pkg::op_t         op_reg;
    logic [HOP_W-1:0]     hop_cur_reg;
    logic [SEQ_W-1:0]     seq_reg;
    logic [DATA_W-1:0]    addr_reg;
    logic [DATA_W-1:0]    time_reg;
    logic [SEQ_AW-1:0]    slot_reg;
    logic [DATA_W-1:0]    rtt_reg;
    prh_pkg::hop_stats_t  stats_reg, stats_next;
    prh_pkg::result_t     out_data_reg, out_data_next;
    logic [1:0]           out_status_reg, out_status_next;

    prh_pkg::in_item_t    in_item;
    logic [HOP_W-1:0]     hop_clamped;
    logic                 accept;
    logic                 out_free;
    logic                 out_load;
    logic                 clr_done;
    logic                 seq_in_range;
    logic                 slot_hit;
    logic                 stats_empty;
    logic [DATA_W-1:0]    alu_sat32;

    logic                 slot_we;
    logic [SEQ_AW-1:0]    slot_waddr;
    prh_pkg::slot_entry_t slot_wdata;
    prh_pkg::slot_entry_t slot_rd;
    logic                 hop_we;
    logic [HOP_AW-1:0]    hop_waddr;
    prh_pkg::hop_stats_t  hop_wdata;
    prh_pkg::hop_stats_t  hop_rd;

    prh_pkg::alu_req_t    alu_req;
    prh_pkg::alu_res_t    alu_res;

    // input decode and handshake
    assign in_item  = prh_pkg::in_item_t'(s_tdata);
    assign s_tready = (state_reg == prh_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign hop_clamped = (32'(in_item.hop_index) >= HOP_COUNT) ? HOP_W'(HOP_COUNT - 1)
                                                               : in_item.hop_index;

    // status terms
    assign out_free     = !out_valid_reg || m_tready;
    assign clr_done     = (clr_cnt_reg == CLR_AW'(CLR_DEPTH - 1));
    assign seq_in_range = (32'(seq_reg) < SEQ_ENTRIES);
    assign slot_hit     = seq_in_range && slot_rd.in_flight;
    assign stats_empty  = (stats_reg.returned == '0);
    assign alu_sat32    = alu_res.sum[DATA_W] ? {DATA_W{1'b1}} : alu_res.sum[DATA_W-1:0];
    assign out_load     = out_free && ((state_reg == prh_pkg::ST_WRITE) ||
                          ((state_reg == prh_pkg::ST_MATCH) && !slot_hit));

    // sequence table: in-flight flag, hop and send time per slot
    prh_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SEQ_ENTRIES)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (slot_we),
        .wr_addr (slot_waddr),
        .wr_data (slot_wdata),
        .rd_addr (SEQ_AW'(seq_reg)),
        .rd_data (slot_rd)
    );

    // hop statistics table
    prh_ram #(
        .WIDTH (STATS_W),
        .DEPTH (HOP_COUNT)
    ) u_hop_ram (
        .clk     (clk),
        .wr_en   (hop_we),
        .wr_addr (hop_waddr),
        .wr_data (hop_wdata),
        .rd_addr (HOP_AW'(hop_cur_reg)),
        .rd_data (hop_rd)
    );

    // shared arithmetic unit
    prh_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prh_pkg::ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = prh_pkg::ST_IDLE;
                end
            end
            prh_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (prh_pkg::op_t'(s_tuser[0]) == prh_pkg::OP_SEND)
                                 ? prh_pkg::ST_PROBE : prh_pkg::ST_LOOKUP;
                end
            end
            prh_pkg::ST_PROBE:  state_next = prh_pkg::ST_LOAD;
            prh_pkg::ST_LOOKUP: state_next = prh_pkg::ST_MATCH;
            prh_pkg::ST_MATCH:
            begin
                if (slot_hit)
                begin
                    state_next = prh_pkg::ST_HOP_RD;
                end
                else if (out_free)
                begin
                    state_next = prh_pkg::ST_IDLE;
                end
            end
            prh_pkg::ST_HOP_RD: state_next = prh_pkg::ST_LOAD;
            prh_pkg::ST_LOAD:
            begin
                state_next = (op_reg == prh_pkg::OP_SEND) ? prh_pkg::ST_SENT
                                                          : prh_pkg::ST_ADDR;
            end
            prh_pkg::ST_ADDR:   state_next = prh_pkg::ST_BEST;
            prh_pkg::ST_BEST:   state_next = prh_pkg::ST_WORST;
            prh_pkg::ST_WORST:  state_next = prh_pkg::ST_TOTAL;
            prh_pkg::ST_TOTAL:  state_next = prh_pkg::ST_RETURN;
            prh_pkg::ST_RETURN: state_next = prh_pkg::ST_WRITE;
            prh_pkg::ST_SENT:   state_next = prh_pkg::ST_WRITE;
            prh_pkg::ST_WRITE:
            begin
                if (out_free)
                begin
                    state_next = prh_pkg::ST_IDLE;
                end
            end
            default:            state_next = prh_pkg::ST_CLEAR;
        endcase
    end

    // table controls and adder operands per state
    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = next_slot_reg;
        slot_wdata = '0;
        hop_we     = 1'b0;
        hop_waddr  = HOP_AW'(hop_cur_reg);
        hop_wdata  = stats_reg;
        alu_req.op = prh_pkg::ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (state_reg)
            prh_pkg::ST_CLEAR:
            begin
                slot_we    = (32'(clr_cnt_reg) < SEQ_ENTRIES);
                slot_waddr = SEQ_AW'(clr_cnt_reg);
                hop_we     = (32'(clr_cnt_reg) < HOP_COUNT);
                hop_waddr  = HOP_AW'(clr_cnt_reg);
                hop_wdata  = '0;
            end
            prh_pkg::ST_PROBE:
            begin
                slot_we              = 1'b1;
                slot_wdata.in_flight = 1'b1;
                slot_wdata.hop       = hop_cur_reg;
                slot_wdata.send_time = time_reg;
            end
            prh_pkg::ST_MATCH:
            begin
                // retire the slot and measure the round trip
                slot_we    = slot_hit;
                slot_waddr = SEQ_AW'(seq_reg);
                alu_req.op = prh_pkg::ALU_SUB;
                alu_req.a  = ALU_W'(time_reg);
                alu_req.b  = ALU_W'(slot_rd.send_time);
            end
            prh_pkg::ST_ADDR:
            begin
                alu_req.a = ALU_W'(stats_reg.inconsist);
                alu_req.b = ALU_W'(1'b1);
            end
            prh_pkg::ST_BEST:
            begin
                alu_req.op = prh_pkg::ALU_SUB;
                alu_req.a  = ALU_W'(rtt_reg);
                alu_req.b  = ALU_W'(stats_reg.best);
            end
            prh_pkg::ST_WORST:
            begin
                alu_req.op = prh_pkg::ALU_SUB;
                alu_req.a  = ALU_W'(stats_reg.worst);
                alu_req.b  = ALU_W'(rtt_reg);
            end
            prh_pkg::ST_TOTAL:
            begin
                alu_req.a = stats_reg.total;
                alu_req.b = ALU_W'(rtt_reg);
            end
            prh_pkg::ST_RETURN:
            begin
                alu_req.a = ALU_W'(stats_reg.returned);
                alu_req.b = ALU_W'(1'b1);
            end
            prh_pkg::ST_SENT:
            begin
                alu_req.a = ALU_W'(stats_reg.sent);
                alu_req.b = ALU_W'(1'b1);
            end
            prh_pkg::ST_WRITE:
            begin
                hop_we = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // statistics update: load the record, then one field per step
    always_comb
    begin
        stats_next = stats_reg;
        unique case (state_reg)
            prh_pkg::ST_LOAD:
            begin
                stats_next = hop_rd;
            end
            prh_pkg::ST_ADDR:
            begin
                // first responder is kept, later different addresses count
                if (stats_reg.addr == '0)
                begin
                    stats_next.addr = addr_reg;
                end
                else if (stats_reg.addr != addr_reg)
                begin
                    stats_next.inconsist = alu_sat32;
                end
            end
            prh_pkg::ST_BEST:
            begin
                if (stats_empty || !alu_res.carry)
                begin
                    stats_next.best = rtt_reg;
                end
            end
            prh_pkg::ST_WORST:
            begin
                if (stats_empty || !alu_res.carry)
                begin
                    stats_next.worst = rtt_reg;
                end
            end
            prh_pkg::ST_TOTAL:
            begin
                stats_next.total = alu_res.carry ? {ALU_W{1'b1}} : alu_res.sum;
            end
            prh_pkg::ST_RETURN:
            begin
                stats_next.returned = alu_sat32;
            end
            prh_pkg::ST_SENT:
            begin
                stats_next.sent = alu_sat32;
            end
            default:
            begin
            end
        endcase
    end

    // result record
    always_comb
    begin
        out_data_next   = '0;
        out_status_next = prh_pkg::STATUS_IGNORED;
        out_data_next.seq_out = seq_reg[SEQ_OUT_W-1:0];
        if (state_reg == prh_pkg::ST_WRITE)
        begin
            out_data_next.hop_out         = hop_cur_reg;
            out_data_next.best_us         = stats_reg.best;
            out_data_next.worst_us        = stats_reg.worst;
            out_data_next.total_us        = stats_reg.total;
            out_data_next.returned_count  = stats_reg.returned;
            out_data_next.sent_count      = stats_reg.sent;
            out_data_next.inconsist_count = stats_reg.inconsist;
            out_data_next.hop_address     = stats_reg.addr;
            if (op_reg == prh_pkg::OP_SEND)
            begin
                out_status_next       = prh_pkg::STATUS_ISSUED;
                out_data_next.seq_out = SEQ_OUT_W'(slot_reg);
            end
            else
            begin
                out_status_next      = prh_pkg::STATUS_ACCEPTED;
                out_data_next.rtt_us = rtt_reg;
            end
        end
    end

    // control next values
    always_comb
    begin
        next_slot_next = next_slot_reg;
        if (state_reg == prh_pkg::ST_PROBE)
        begin
            next_slot_next = (next_slot_reg == SEQ_AW'(SEQ_ENTRIES - 1)) ? '0
                                                                          : next_slot_reg + 1'b1;
        end
        clr_cnt_next = clr_cnt_reg;
        if ((state_reg == prh_pkg::ST_CLEAR) && !clr_done)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prh_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
            next_slot_reg <= '0;
            clr_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            next_slot_reg <= next_slot_next;
            clr_cnt_reg   <= clr_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= prh_pkg::op_t'(s_tuser[0]);
            hop_cur_reg <= hop_clamped;
            seq_reg     <= in_item.seq_number;
            addr_reg    <= in_item.reply_addr;
            time_reg    <= in_item.timestamp_us;
        end
        else if ((state_reg == prh_pkg::ST_MATCH) && slot_hit)
        begin
            hop_cur_reg <= slot_rd.hop;
        end
        if (state_reg == prh_pkg::ST_PROBE)
        begin
            slot_reg <= next_slot_reg;
        end
        if (state_reg == prh_pkg::ST_MATCH)
        begin
            rtt_reg <= alu_res.sum[DATA_W-1:0];
        end
        stats_reg <= stats_next;
        if (out_load)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    // output channel
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;

endmodule

FILE: rtl/prh_checker.sv
// port-level assertions for the probe rtt hop statistics block, with bind
module prh_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [prh_pkg::S_TDATA_W-1:0] s_tdata,
    input logic [0:0]                    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [prh_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [1:0]                    m_tuser
);

    prh_pkg::result_t res;

    assign res = prh_pkg::result_t'(m_tdata);

    // one item at a time: busy right after a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on two consecutive cycles");

    // stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // ignored reply carries zero hop, rtt, sent and returned counts and total
    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == prh_pkg::STATUS_IGNORED) |->
            (res.hop_out == '0) && (res.rtt_us == '0) && (res.sent_count == '0) &&
            (res.returned_count == '0) && (res.total_us == '0))
        else $error("ignored reply carries statistics");

    // probe result has no rtt and at least one transmit
    a_probe_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == prh_pkg::STATUS_ISSUED) |->
            (res.rtt_us == '0) && (res.sent_count != '0))
        else $error("probe result inconsistent");

    // accepted reply keeps best within worst and counts the return
    a_reply_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == prh_pkg::STATUS_ACCEPTED) |->
            (res.best_us <= res.worst_us) && (res.returned_count != '0) &&
            (res.best_us <= res.rtt_us) && (res.rtt_us <= res.worst_us))
        else $error("reply statistics out of order");

endmodule

bind probe_rtt_hop_statistics prh_checker u_prh_checker (.*);

FILE: test/probe_rtt_hop_statistics_monitor.sv
// transaction monitor that predicts and checks every result of the probe rtt hop statistics block
module probe_rtt_hop_statistics_monitor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [prh_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [0:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [prh_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic [1:0]                      m_tuser,
    output int                              mismatches,
    output int                              awaited,
    output int                              results_seen
);

    localparam int SLOTS   = 256;
    localparam int HOPS    = 32;
    localparam int HOP_W   = prh_pkg::HOP_W;
    localparam int DATA_W  = prh_pkg::DATA_W;
    localparam int TOTAL_W = prh_pkg::TOTAL_W;

    // status plus result fields of one transaction
    typedef struct packed {
        logic [1:0]       status;
        prh_pkg::result_t fields;
    } hop_report_t;

    // mirror of the sequence table
    logic [7:0]         issue_slot;
    logic               slot_busy [SLOTS];
    logic [HOP_W-1:0]   slot_owner [SLOTS];
    logic [DATA_W-1:0]  slot_stamp [SLOTS];

    // mirror of the per-hop statistics
    logic [DATA_W-1:0]  hop_responder [HOPS];
    logic [DATA_W-1:0]  hop_mismatch [HOPS];
    logic [DATA_W-1:0]  hop_probes [HOPS];
    logic [DATA_W-1:0]  hop_answers [HOPS];
    logic [DATA_W-1:0]  hop_best_rtt [HOPS];
    logic [DATA_W-1:0]  hop_worst_rtt [HOPS];
    logic [TOTAL_W-1:0] hop_rtt_sum [HOPS];

    hop_report_t pending_reports [$];

    function automatic logic [DATA_W-1:0] bump32(logic [DATA_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // apply one input transaction to the mirrored state and build its report
    function automatic hop_report_t predict_report(prh_pkg::op_t op, prh_pkg::in_item_t item);
        hop_report_t        rep;
        logic [HOP_W-1:0]   h;
        logic [7:0]         slot;
        logic [DATA_W-1:0]  rtt;
        logic [TOTAL_W:0]   sum;
        rep = '0;
        if (op == prh_pkg::OP_SEND)
        begin
            // five hop bits never exceed the hop table, so no clamp applies
            h = item.hop_index;
            slot = issue_slot;
            issue_slot = issue_slot + 1'b1;
            slot_busy[slot] = 1'b1;
            slot_owner[slot] = h;
            slot_stamp[slot] = item.timestamp_us;
            hop_probes[h] = bump32(hop_probes[h]);
            rep.status = prh_pkg::STATUS_ISSUED;
            rep.fields.seq_out = slot;
        end
        else if (item.seq_number >= SLOTS || !slot_busy[item.seq_number[7:0]])
        begin
            rep.status = prh_pkg::STATUS_IGNORED;
            rep.fields.seq_out = item.seq_number[7:0];
            return rep;
        end
        else
        begin
            slot = item.seq_number[7:0];
            slot_busy[slot] = 1'b0;
            h = slot_owner[slot];
            rtt = item.timestamp_us - slot_stamp[slot];
            // first nonzero responder sticks, later different ones are counted
            if (hop_responder[h] == '0)
                hop_responder[h] = item.reply_addr;
            else if (hop_responder[h] != item.reply_addr)
                hop_mismatch[h] = bump32(hop_mismatch[h]);
            if (hop_answers[h] == '0)
            begin
                hop_best_rtt[h] = rtt;
                hop_worst_rtt[h] = rtt;
            end
            if (rtt < hop_best_rtt[h])
                hop_best_rtt[h] = rtt;
            if (rtt > hop_worst_rtt[h])
                hop_worst_rtt[h] = rtt;
            sum = {1'b0, hop_rtt_sum[h]} + (TOTAL_W + 1)'(rtt);
            hop_rtt_sum[h] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            hop_answers[h] = bump32(hop_answers[h]);
            rep.status = prh_pkg::STATUS_ACCEPTED;
            rep.fields.seq_out = slot;
            rep.fields.rtt_us = rtt;
        end
        rep.fields.hop_out = h;
        rep.fields.best_us = hop_best_rtt[h];
        rep.fields.worst_us = hop_worst_rtt[h];
        rep.fields.total_us = hop_rtt_sum[h];
        rep.fields.returned_count = hop_answers[h];
        rep.fields.sent_count = hop_probes[h];
        rep.fields.inconsist_count = hop_mismatch[h];
        rep.fields.hop_address = hop_responder[h];
        return rep;
    endfunction

    task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    initial
    begin
        mismatches = 0;
        awaited = 0;
        results_seen = 0;
    end

    // watch both channels on every rising edge
    always @(posedge clk)
    begin
        hop_report_t      want;
        prh_pkg::result_t got;
        if (!rst_n)
        begin
            issue_slot = '0;
            for (int i = 0; i < SLOTS; i++)
                slot_busy[i] = 1'b0;
            for (int i = 0; i < HOPS; i++)
            begin
                hop_responder[i] = '0;
                hop_mismatch[i] = '0;
                hop_probes[i] = '0;
                hop_answers[i] = '0;
                hop_best_rtt[i] = '0;
                hop_worst_rtt[i] = '0;
                hop_rtt_sum[i] = '0;
            end
            pending_reports.delete();
        end
        else
        begin
            // result transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = m_tdata;
                if (pending_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, got status %0d data %0h",
                        $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    check_field("status", 48'(want.status), 48'(m_tuser));
                    check_field("hop_out", 48'(want.fields.hop_out), 48'(got.hop_out));
                    check_field("seq_out", 48'(want.fields.seq_out), 48'(got.seq_out));
                    check_field("rtt_us", 48'(want.fields.rtt_us), 48'(got.rtt_us));
                    check_field("best_us", 48'(want.fields.best_us), 48'(got.best_us));
                    check_field("worst_us", 48'(want.fields.worst_us), 48'(got.worst_us));
                    check_field("total_us", want.fields.total_us, got.total_us);
                    check_field("returned_count", 48'(want.fields.returned_count),
                        48'(got.returned_count));
                    check_field("sent_count", 48'(want.fields.sent_count),
                        48'(got.sent_count));
                    check_field("inconsist_count", 48'(want.fields.inconsist_count),
                        48'(got.inconsist_count));
                    check_field("hop_address", 48'(want.fields.hop_address),
                        48'(got.hop_address));
                end
            end
            // input transaction updates the mirror
            if (s_tvalid && s_tready)
                pending_reports.push_back(predict_report(prh_pkg::op_t'(s_tuser),
                    prh_pkg::in_item_t'(s_tdata)));
        end
        awaited = pending_reports.size();
    end

endmodule

FILE: test/tb_probe_rtt_hop_statistics.sv
// testbench top for the probe rtt hop statistics block: stimulus, flow control and verdict
module tb_probe_rtt_hop_statistics;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int ITEMS_PER_PASS = 250;
    localparam int DRAIN_CYCLES   = 24;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [prh_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [0:0]                    s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [prh_pkg::M_TDATA_W-1:0] m_tdata;
    logic [1:0]                    m_tuser;

    int mismatches;
    int awaited;
    int results_seen;

    // flow control pressure, in percent of cycles
    int tx_idle_pct = 37;
    int rx_idle_pct = 79;
    int cycles = 0;

    // stimulus-side view of outstanding probes, used to aim replies
    int               probes_issued = 0;
    int               replies_issued = 0;
    int               live_slots [$];
    logic             slot_live [256];
    logic [4:0]       probe_hop [256];
    logic [31:0]      probe_sent_at [256];
    logic [31:0]      responder_ip [32];
    logic [31:0]      now_us;
    int               last_answered = 0;

    probe_rtt_hop_statistics dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    probe_rtt_hop_statistics_monitor u_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .mismatches   (mismatches),
        .awaited      (awaited),
        .results_seen (results_seen)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // result side stalls at random
    always @(negedge clk)
    begin
        m_tready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // watchdog
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // drive one input transaction and wait for it to be taken
    task automatic push_item(prh_pkg::op_t op, logic [4:0] hop, logic [15:0] seq,
                             logic [31:0] addr, logic [31:0] ts);
        prh_pkg::in_item_t item;
        item.pad = '0;
        item.hop_index = hop;
        item.seq_number = seq;
        item.reply_addr = addr;
        item.timestamp_us = ts;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= item;
        s_tuser <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // probe with junk in the reply-only fields
    task automatic send_probe(logic [4:0] hop, logic [31:0] ts);
        logic [7:0] slot;
        slot = 8'(probes_issued);
        if (!slot_live[slot])
            live_slots.push_back(int'(slot));
        slot_live[slot] = 1'b1;
        probe_hop[slot] = hop;
        probe_sent_at[slot] = ts;
        probes_issued++;
        push_item(prh_pkg::OP_SEND, hop, 16'($urandom_range(0, 65535)), $urandom, ts);
    endtask

    task automatic send_reply(logic [15:0] seq, logic [31:0] addr, logic [31:0] ts);
        if (seq < 256 && slot_live[seq[7:0]])
        begin
            slot_live[seq[7:0]] = 1'b0;
            last_answered = int'(seq);
            for (int i = 0; i < live_slots.size(); i++)
            begin
                if (live_slots[i] == seq)
                begin
                    live_slots.delete(i);
                    break;
                end
            end
        end
        replies_issued++;
        push_item(prh_pkg::OP_REPLY, 5'($urandom_range(0, 31)), seq, addr, ts);
    endtask

    // mostly probes and matching replies, the rest stale or out-of-range replies
    task automatic random_item();
        int          roll;
        logic [7:0]  pick;
        int          spread;
        logic [31:0] rtt;
        logic [31:0] addr;
        now_us = now_us + $urandom_range(1, 3000);
        roll = $urandom_range(0, 99);
        if (roll < 48 || live_slots.size() == 0)
            send_probe(5'($urandom_range(0, 31)), now_us);
        else if (roll < 85)
        begin
            pick = 8'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
            spread = $urandom_range(0, 19);
            if (spread == 0)
                rtt = 0;
            else if (spread == 1)
                rtt = $urandom;
            else
                rtt = $urandom_range(1, 250000);
            spread = $urandom_range(0, 19);
            if (spread == 0)
                addr = 0;
            else if (spread < 3)
                addr = $urandom;
            else
                addr = responder_ip[probe_hop[pick]];
            send_reply({8'h00, pick}, addr, probe_sent_at[pick] + rtt);
        end
        else if (roll < 89)
            send_reply(16'(last_answered), $urandom, now_us);
        else if (roll < 95)
            send_reply(16'($urandom_range(0, 255)), $urandom, now_us);
        else
            send_reply(16'($urandom_range(256, 65535)), $urandom, $urandom);
    endtask

    initial
    begin
        for (int i = 0; i < 256; i++)
            slot_live[i] = 1'b0;
        for (int i = 0; i < 32; i++)
            responder_ip[i] = $urandom | 32'h1;
        now_us = $urandom;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: ignored replies, zero address, wrapping and extreme rtt
        send_reply(16'd0, 32'h0102_0304, 32'h0);
        send_reply(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_reply(16'd256, 32'h0, 32'h0);
        send_probe(5'd0, 32'h0);
        send_probe(5'd31, 32'hFFFF_FFF0);
        send_probe(5'd31, 32'd100);
        send_reply(16'd0, 32'h0, 32'd5);
        send_reply(16'd0, 32'h0102_0304, 32'd9);
        send_reply(16'd1, 32'hFFFF_FFFF, 32'h10);
        send_reply(16'd2, 32'h0A00_0001, 32'd100 + 32'd1000000);
        send_probe(5'd0, 32'd200);
        send_reply(16'd3, 32'hC0A8_0001, 32'd200);
        send_probe(5'd5, 32'd1);
        send_reply(16'd4, 32'h0A0A_0A0A, 32'd0);
        send_probe(5'd5, 32'h8000_0000);
        send_reply(16'd5, 32'h0A0A_0A0A, 32'h8000_0003);
        send_reply(16'd255, 32'h0A0A_0A0A, 32'd7);

        // random: three flow control settings
        for (int pass = 0; pass < 3; pass++)
        begin
            @(posedge clk);
            tx_idle_pct = (pass == 0) ? 37 : (pass == 1) ? 79 : 0;
            rx_idle_pct = (pass == 0) ? 79 : (pass == 1) ? 37 : 0;
            @(negedge clk);
            for (int n = 0; n < ITEMS_PER_PASS; n++)
                random_item();
        end
        s_tvalid <= 1'b0;

        // drain
        while (awaited != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("covered %0d probe and %0d reply transactions under three stall patterns",
            probes_issued, replies_issued);
        $display("%0d results compared, slot table wrapped %0d times",
            results_seen, probes_issued / 256);
        if (mismatches == 0 && awaited == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/prh_pkg.sv
rtl/prh_ram.sv
rtl/prh_alu.sv
rtl/probe_rtt_hop_statistics.sv
rtl/prh_checker.sv
test/probe_rtt_hop_statistics_monitor.sv
test/tb_probe_rtt_hop_statistics.sv
